@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the quoted token unescaper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

@@ rtl/quo_pkg.sv @@
// Types and constants shared by the quoted token unescaper modules.
`default_nettype none

package quo_pkg;

    // Result kinds
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_END_OK  = 2'd1;
    localparam logic [1:0] KIND_END_ERR = 2'd2;

    // Results one character can cause, and result queue depth
    localparam int MAX_BATCH = 3;
    localparam int RES_DEPTH = 4;

    localparam logic [15:0] LENGTH_MAX = 16'd65535;

    typedef enum logic [2:0] {
        PH_SKIP   = 3'b001,
        PH_PREFIX = 3'b010,
        PH_TOKEN  = 3'b100
    } quo_phase_t;

    typedef enum logic [1:0] {
        DL_UNQ    = 2'd0,
        DL_SINGLE = 2'd1,
        DL_DOUBLE = 2'd2
    } quo_delim_t;

    typedef enum logic [1:0] {
        PF_NONE = 2'd0,
        PF_HEX  = 2'd1,
        PF_FILE = 2'd2
    } quo_prefix_t;

    typedef enum logic [1:0] {
        HX_IDLE   = 2'd0,
        HX_OPEN   = 2'd1,
        HX_DIGITS = 2'd2
    } quo_hexesc_t;

    typedef enum logic [1:0] {
        SP_RUN   = 2'd0,
        SP_QUIET = 2'd1,
        SP_ERROR = 2'd2
    } quo_stop_t;

    // Input transaction payload
    typedef struct packed {
        logic [7:0] char_in;
        logic       line_end;
    } quo_in_t;

    // Result transaction payload
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] token_length;
        logic        file_reference;
        logic        last;
    } quo_out_t;

    // Tokenizer state
    typedef struct packed {
        quo_phase_t  phase;
        quo_delim_t  delim;
        quo_prefix_t prefix;
        logic        esc;
        quo_hexesc_t hexcnt;
        logic [7:0]  hexval;
        logic        has_digit;
        logic [3:0]  nibble;
        quo_stop_t   stopped;
        logic [15:0] length;
    } quo_state_t;

    // Results of one character, in order
    typedef struct packed {
        logic [1:0]                count;
        quo_out_t [MAX_BATCH-1:0]  item;
    } quo_batch_t;

    localparam quo_state_t STATE_RESET = '{
        phase:     PH_SKIP,
        delim:     DL_UNQ,
        prefix:    PF_NONE,
        esc:       1'b0,
        hexcnt:    HX_IDLE,
        hexval:    8'h00,
        has_digit: 1'b0,
        nibble:    4'h0,
        stopped:   SP_RUN,
        length:    16'h0000
    };

endpackage

`default_nettype wire

@@ rtl/quo_step.sv @@
// Next-state and result logic for one character of the command line.
`default_nettype none

module quo_step (
    input  quo_pkg::quo_state_t cur_state,
    input  quo_pkg::quo_in_t    item,
    output quo_pkg::quo_state_t new_state,
    output quo_pkg::quo_batch_t batch
);
    import quo_pkg::*;

    localparam logic [7:0] CH_TAB_LO   = 8'h09;
    localparam logic [7:0] CH_TAB_HI   = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_DQUOTE   = 8'h22;
    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_SQUOTE   = 8'h27;
    localparam logic [7:0] CH_LT       = 8'h3C;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] HEX_MAX     = 8'd15;
    localparam logic [7:0] HEX_ALPHA   = 8'd10;
    localparam logic [7:0] CLASS_SPACE = 8'd254;
    localparam logic [7:0] CLASS_OTHER = 8'd255;

    // Working copy: state plus the results gathered so far
    typedef struct packed {
        quo_state_t               s;
        logic [1:0]               n;
        quo_out_t [MAX_BATCH-1:0] r;
    } quo_work_t;

    // Hex value 0..15, whitespace class or other class
    function automatic logic [7:0] digit_class(input logic [7:0] c);
        logic [7:0] d;
        if (c inside {[8'h30:8'h39]})
            d = c - 8'h30;
        else if (c inside {[8'h61:8'h66]})
            d = c - 8'h61 + HEX_ALPHA;
        else if (c inside {[8'h41:8'h46]})
            d = c - 8'h41 + HEX_ALPHA;
        else if (c == CH_SPACE || c inside {[CH_TAB_LO:CH_TAB_HI]})
            d = CLASS_SPACE;
        else
            d = CLASS_OTHER;
        return d;
    endfunction

    function automatic quo_work_t put_result(input quo_work_t wi, input logic [1:0] kind,
                                             input logic [7:0] b, input logic [15:0] len);
        quo_work_t w;
        w = wi;
        if (w.n != 2'(MAX_BATCH))
        begin
            w.r[w.n].kind           = kind;
            w.r[w.n].data_byte      = b;
            w.r[w.n].token_length   = len;
            w.r[w.n].file_reference = 1'b0;
            w.r[w.n].last           = 1'b0;
            w.n                     = w.n + 2'd1;
        end
        return w;
    endfunction

    // Data byte out, token length saturates
    function automatic quo_work_t put_data(input quo_work_t wi, input logic [7:0] b);
        quo_work_t w;
        w = put_result(wi, KIND_DATA, b, 16'h0000);
        if (w.s.length != LENGTH_MAX)
            w.s.length = w.s.length + 16'd1;
        return w;
    endfunction

    // Decoded byte: passed on, or packed as hex digit pairs in '$' mode
    function automatic quo_work_t feed_byte(input quo_work_t wi, input logic [7:0] b);
        quo_work_t  w;
        logic [7:0] d;
        w = wi;
        d = digit_class(b);
        if (w.s.prefix != PF_HEX)
        begin
            w = put_data(w, b);
        end
        else if (w.s.stopped == SP_RUN)
        begin
            if (d == CLASS_OTHER)
            begin
                if (w.s.has_digit)
                begin
                    w = put_data(w, {4'h0, w.s.nibble});
                    w.s.has_digit = 1'b0;
                end
                w.s.stopped = (b == 8'h00) ? SP_QUIET : SP_ERROR;
            end
            else if (d == CLASS_SPACE)
            begin
                if (w.s.has_digit)
                begin
                    w = put_data(w, {4'h0, w.s.nibble});
                    w.s.has_digit = 1'b0;
                end
            end
            else if (w.s.has_digit)
            begin
                w = put_data(w, {w.s.nibble, d[3:0]});
                w.s.has_digit = 1'b0;
            end
            else
            begin
                w.s.nibble    = d[3:0];
                w.s.has_digit = 1'b1;
            end
        end
        return w;
    endfunction

    // Flush pending bytes, emit token end, back to skipping spaces
    function automatic quo_work_t finish(input quo_work_t wi, input logic unclosed);
        quo_work_t w;
        logic      err;
        w = wi;
        if (w.s.hexcnt == HX_DIGITS)
            w = feed_byte(w, w.s.hexval);
        w.s.hexcnt = HX_IDLE;
        if (w.s.prefix == PF_HEX && w.s.stopped == SP_RUN && w.s.has_digit)
        begin
            w = put_data(w, {4'h0, w.s.nibble});
            w.s.has_digit = 1'b0;
        end
        err = unclosed || (w.s.stopped == SP_ERROR);
        w = put_result(w, err ? KIND_END_ERR : KIND_END_OK, 8'h00, w.s.length);
        w.s = STATE_RESET;
        return w;
    endfunction

    // One character inside a token
    function automatic quo_work_t token_char(input quo_work_t wi, input logic [7:0] c);
        quo_work_t  w;
        logic [7:0] d;
        logic [7:0] dch;
        logic       done;
        w    = wi;
        done = 1'b0;
        d    = digit_class(c);
        // hex escape: collect digits, a non-digit closes it
        if (w.s.hexcnt != HX_IDLE)
        begin
            if (d <= HEX_MAX)
            begin
                w.s.hexval = {w.s.hexval[3:0], d[3:0]};
                w.s.hexcnt = HX_DIGITS;
                done       = 1'b1;
            end
            else
            begin
                if (w.s.hexcnt == HX_DIGITS)
                    w = feed_byte(w, w.s.hexval);
                w.s.hexcnt = HX_IDLE;
            end
        end
        case (w.s.delim)
            DL_SINGLE: dch = CH_SQUOTE;
            DL_DOUBLE: dch = CH_DQUOTE;
            default:   dch = CH_SPACE;
        endcase
        if (!done)
        begin
            if (!w.s.esc && c == dch)
            begin
                w = finish(w, 1'b0);
            end
            else if (w.s.delim == DL_DOUBLE && !w.s.esc && c == CH_BSLASH)
            begin
                w.s.esc = 1'b1;
            end
            else if (w.s.esc)
            begin
                w.s.esc = 1'b0;
                case (c)
                    8'h61:   w = feed_byte(w, 8'd7);    // a
                    8'h62:   w = feed_byte(w, 8'd8);    // b
                    8'h65:   w = feed_byte(w, 8'd27);   // e
                    8'h66:   w = feed_byte(w, 8'd12);   // f
                    8'h6E:   w = feed_byte(w, 8'd10);   // n
                    8'h72:   w = feed_byte(w, 8'd13);   // r
                    8'h74:   w = feed_byte(w, 8'd9);    // t
                    8'h76:   w = feed_byte(w, 8'd11);   // v
                    8'h78:                              // x
                    begin
                        w.s.hexcnt = HX_OPEN;
                        w.s.hexval = 8'h00;
                    end
                    default: w = feed_byte(w, c);
                endcase
            end
            else
            begin
                w = feed_byte(w, c);
            end
        end
        return w;
    endfunction

    // First character of a token: opening quote or first byte
    function automatic quo_work_t start_token(input quo_work_t wi, input logic [7:0] c);
        quo_work_t w;
        w         = wi;
        w.s.phase = PH_TOKEN;
        if (c == CH_DQUOTE)
            w.s.delim = DL_DOUBLE;
        else if (c == CH_SQUOTE)
            w.s.delim = DL_SINGLE;
        else
        begin
            w.s.delim = DL_UNQ;
            w = token_char(w, c);
        end
        return w;
    endfunction

    quo_work_t  work;
    logic       eol;
    logic [7:0] c;

    // Character dispatch by phase
    always_comb
    begin
        work   = '{s: cur_state, n: 2'd0, r: '0};
        c      = item.char_in;
        eol    = item.line_end || (c == 8'h00);
        if (eol)
        begin
            case (cur_state.phase)
                PH_PREFIX: work = finish(work, 1'b0);
                PH_TOKEN:  work = finish(work, cur_state.delim != DL_UNQ);
                default:   work.s.phase = PH_SKIP;
            endcase
        end
        else
        begin
            case (cur_state.phase)
                PH_SKIP:
                begin
                    if (c == CH_DOLLAR)
                    begin
                        work.s.prefix = PF_HEX;
                        work.s.phase  = PH_PREFIX;
                    end
                    else if (c == CH_LT)
                    begin
                        work.s.prefix = PF_FILE;
                        work.s.phase  = PH_PREFIX;
                    end
                    else if (c != CH_SPACE)
                    begin
                        work = start_token(work, c);
                    end
                end
                PH_PREFIX: work = start_token(work, c);
                PH_TOKEN:  work = token_char(work, c);
                default:   work.s = STATE_RESET;
            endcase
        end
    end

    // File flag from the prefix held before this character; mark the final result
    always_comb
    begin
        new_state   = work.s;
        batch.count = work.n;
        for (int i = 0; i < MAX_BATCH; i++)
        begin
            batch.item[i]                = work.r[i];
            batch.item[i].file_reference = (cur_state.prefix == PF_FILE);
            batch.item[i].last           = (work.n == 2'(i + 1));
        end
    end

endmodule

`default_nettype wire

@@ rtl/quo_res_fifo.sv @@
// Result queue: takes up to three results per cycle, hands out one.
`default_nettype none

`include "assert_macros.svh"

module quo_res_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  quo_pkg::quo_batch_t push,
    output logic                room,
    output logic                res_valid,
    input  logic                res_ready,
    output quo_pkg::quo_out_t   res_item
);
    import quo_pkg::*;

    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int CNT_W = $clog2(RES_DEPTH + 1);

    quo_out_t         mem_reg [RES_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] count_after_pop;
    logic             pop;

    // Handshake and free space for a full batch
    assign pop             = res_valid && res_ready;
    assign res_valid       = (count_reg != '0);
    assign res_item        = mem_reg[rd_ptr_reg];
    assign count_after_pop = count_reg - CNT_W'(pop);
    assign room            = (count_after_pop <= CNT_W'(RES_DEPTH - MAX_BATCH));

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_after_pop + CNT_W'(push.count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage write, results in order
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_BATCH; i++)
        begin
            if (2'(i) < push.count)
                mem_reg[wr_ptr_reg + PTR_W'(i)] <= push.item[i];
        end
    end

    `ASSERT_NEVER(a_fifo_overflow, clk, rst_n, count_reg > CNT_W'(RES_DEPTH))
    `ASSERT_CLK(a_push_needs_room, clk, rst_n, (push.count != 2'd0) |-> room)
    `ASSERT_CLK(a_ptr_track, clk, rst_n, wr_ptr_reg == rd_ptr_reg + PTR_W'(count_reg))

endmodule

`default_nettype wire

@@ rtl/quoted_token_unescaper.sv @@
// Top level of the quoted token unescaper: input register, step logic, result queue.
//
//   channel | valid      | ready      | payload
//   --------+------------+------------+------------------------------------------
//   char    | char_valid | char_ready | char_item: char_in, line_end
//   result  | res_valid  | res_ready  | res_item: kind, data_byte, token_length,
//           |            |            |           file_reference, last
//
// One character is taken per cycle while the queue has room; it is held in the input
// register and decoded there, and its results are written to the queue and leave it
// one per cycle while res_ready is high. A character waits in the input register until
// the queue, counted after this cycle's pop, has room for a full batch of three.
// Reset clears the tokenizer state, the input register flag and the queue.
// A stalled result side fills the queue until it lacks room for a full batch, and then
// drops char_ready.
`default_nettype none

`include "assert_macros.svh"

module quoted_token_unescaper (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_valid,
    output logic              char_ready,
    input  quo_pkg::quo_in_t  char_item,
    output logic              res_valid,
    input  logic              res_ready,
    output quo_pkg::quo_out_t res_item
);
    import quo_pkg::*;

    quo_in_t    in_reg;
    logic       in_valid_reg, in_valid_next;
    quo_state_t state_reg, state_next;
    quo_state_t step_state;
    quo_batch_t step_batch;
    quo_batch_t push;
    logic       room;
    logic       proc_fire;
    logic       accept;
    logic [1:0] last_idx;
    logic       hold_in;
    logic       batch_any;
    logic       batch_ends;

    // Input register handshake
    assign proc_fire  = in_valid_reg && room;
    assign char_ready = !in_valid_reg || proc_fire;
    assign accept     = char_valid && char_ready;

    quo_step u_step (
        .cur_state (state_reg),
        .item      (in_reg),
        .new_state (step_state),
        .batch     (step_batch)
    );

    // Push results only when the character is consumed
    always_comb
    begin
        push       = step_batch;
        push.count = proc_fire ? step_batch.count : 2'd0;
        state_next = proc_fire ? step_state : state_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (proc_fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= STATE_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_reg <= char_item;
    end

    quo_res_fifo u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    // Terms used by the checks below
    assign last_idx   = step_batch.count - 2'd1;
    assign hold_in    = in_valid_reg && !proc_fire;
    assign batch_any  = proc_fire && (step_batch.count != 2'd0);
    assign batch_ends = batch_any && (step_batch.item[last_idx].kind != KIND_DATA);

    `ASSERT_CLK(a_hold_input, clk, rst_n, hold_in |=> (in_valid_reg && $stable(in_reg)))
    `ASSERT_CLK(a_batch_last, clk, rst_n, batch_any |-> step_batch.item[last_idx].last)
    `ASSERT_CLK(a_end_resets, clk, rst_n, batch_ends |=> (state_reg.phase == PH_SKIP))

endmodule

`default_nettype wire

@@ tb/quoted_token_unescaper_tb.sv @@
// Self-checking testbench for the quoted token unescaper: directed table, random lines.
`timescale 1ns / 100ps

module quoted_token_unescaper_tb;
    import quo_pkg::*;

    // Characters with a role in the token syntax
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Character classes for hex packing
    localparam logic [7:0] CLS_SPACE = 8'd254;
    localparam logic [7:0] CLS_OTHER = 8'd255;

    localparam int RANDOM_ITEMS   = 96;
    localparam int TAIL_ITEMS     = 20;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [7:0] ESC_PICK [12] = '{"a", "b", "e", "f", "n", "r", "t", "v", "x",
                                             "q", CH_BSLASH, CH_DQUOTE};

    // One character transaction, optionally with its single result typed in
    typedef struct packed {
        logic [7:0] ch;
        logic       le;
        logic       typed;
        logic       has_want;
        quo_out_t   want;
    } char_row_t;

    localparam quo_out_t NO_RESULT = '0;
    localparam int DIR_N = 24;

    localparam char_row_t DIRECTED_ROWS [DIR_N] = '{
        // idle line: nothing comes out
        '{CH_SPACE,  1'b0, 1'b1, 1'b0, NO_RESULT},
        '{8'hFF,     1'b1, 1'b1, 1'b0, NO_RESULT},
        // unquoted token of the top byte, ended by a zero character
        '{8'hFF,     1'b0, 1'b1, 1'b1, '{KIND_DATA,   8'hFF, 16'd0, 1'b0, 1'b1}},
        '{8'h00,     1'b0, 1'b1, 1'b1, '{KIND_END_OK, 8'h00, 16'd1, 1'b0, 1'b1}},
        // double quotes: long hex escape, newline escape, left open
        '{CH_DQUOTE, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{CH_BSLASH, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{"x",       1'b0, 1'b0, 1'b0, NO_RESULT},
        '{"4",       1'b0, 1'b0, 1'b0, NO_RESULT},
        '{"1",       1'b0, 1'b0, 1'b0, NO_RESULT},
        '{"2",       1'b0, 1'b0, 1'b0, NO_RESULT},
        '{CH_BSLASH, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{"n",       1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'h00,     1'b1, 1'b1, 1'b1, '{KIND_END_ERR, 8'h00, 16'd2, 1'b0, 1'b1}},
        // hex packing: lone digit, pair, then a bad character
        '{CH_DOLLAR, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{CH_DQUOTE, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{"a",       1'b0, 1'b0, 1'b0, NO_RESULT},
        '{CH_SPACE,  1'b0, 1'b0, 1'b0, NO_RESULT},
        '{"B",       1'b0, 1'b0, 1'b0, NO_RESULT},
        '{"7",       1'b0, 1'b0, 1'b0, NO_RESULT},
        '{"z",       1'b0, 1'b0, 1'b0, NO_RESULT},
        '{CH_DQUOTE, 1'b0, 1'b1, 1'b1, '{KIND_END_ERR, 8'h00, 16'd2, 1'b0, 1'b1}},
        // file reference token
        '{CH_LT,     1'b0, 1'b0, 1'b0, NO_RESULT},
        '{"k",       1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'h00,     1'b1, 1'b1, 1'b1, '{KIND_END_OK, 8'h00, 16'd1, 1'b1, 1'b1}}
    };

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     char_valid = 1'b0;
    logic     char_ready;
    quo_in_t  char_item = '0;
    logic     res_valid;
    logic     res_ready = 1'b0;
    quo_out_t res_item;

    quoted_token_unescaper u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_item   (res_item)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    char_row_t  char_feed [$];
    quo_out_t   expected_results [$];
    quo_out_t   step_results [$];
    quo_state_t tok = STATE_RESET;
    int         mismatch_count = 0;
    bit         quiet_tail = 1'b0;

    // ---------------------------------------------------------------
    // Tokenizer prediction
    // ---------------------------------------------------------------

    // 0..15 for a hex digit, else space or other class
    function automatic logic [7:0] hex_class(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 8'd10;
        if (c >= "A" && c <= "F") return c - "A" + 8'd10;
        if (c == CH_SPACE || (c >= 8'd9 && c <= 8'd13)) return CLS_SPACE;
        return CLS_OTHER;
    endfunction

    function automatic void emit_result(logic [1:0] kind, logic [7:0] b, logic [15:0] len);
        quo_out_t r;
        if (step_results.size() >= MAX_BATCH) return;
        r.kind           = kind;
        r.data_byte      = b;
        r.token_length   = len;
        r.file_reference = (tok.prefix == PF_FILE);
        r.last           = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void emit_byte(logic [7:0] b);
        emit_result(KIND_DATA, b, 16'd0);
        if (tok.length != LENGTH_MAX) tok.length++;
    endfunction

    // Decoded byte: passed through, or packed from hex digit pairs
    function automatic void pack_byte(logic [7:0] b);
        logic [7:0] d;
        if (tok.prefix != PF_HEX)
        begin
            emit_byte(b);
            return;
        end
        if (tok.stopped != SP_RUN) return;
        d = hex_class(b);
        if (d == CLS_OTHER || d == CLS_SPACE)
        begin
            if (tok.has_digit)
            begin
                emit_byte({4'h0, tok.nibble});
                tok.has_digit = 1'b0;
            end
            if (d == CLS_OTHER) tok.stopped = (b == 8'h00) ? SP_QUIET : SP_ERROR;
        end
        else if (tok.has_digit)
        begin
            emit_byte({tok.nibble, d[3:0]});
            tok.has_digit = 1'b0;
        end
        else
        begin
            tok.nibble    = d[3:0];
            tok.has_digit = 1'b1;
        end
    endfunction

    function automatic void close_token(bit unclosed);
        if (tok.hexcnt == HX_DIGITS) pack_byte(tok.hexval);
        tok.hexcnt = HX_IDLE;
        if (tok.prefix == PF_HEX && tok.stopped == SP_RUN && tok.has_digit)
        begin
            emit_byte({4'h0, tok.nibble});
            tok.has_digit = 1'b0;
        end
        emit_result((unclosed || tok.stopped == SP_ERROR) ? KIND_END_ERR : KIND_END_OK,
                    8'h00, tok.length);
        tok = STATE_RESET;
    endfunction

    function automatic void take_token_char(logic [7:0] c);
        logic [7:0] d;
        logic [7:0] closer;
        // an open hex escape swallows digits, anything else ends it
        if (tok.hexcnt != HX_IDLE)
        begin
            d = hex_class(c);
            if (d < 8'd16)
            begin
                tok.hexval = {tok.hexval[3:0], d[3:0]};
                tok.hexcnt = HX_DIGITS;
                return;
            end
            if (tok.hexcnt == HX_DIGITS) pack_byte(tok.hexval);
            tok.hexcnt = HX_IDLE;
        end
        case (tok.delim)
            DL_SINGLE: closer = CH_SQUOTE;
            DL_DOUBLE: closer = CH_DQUOTE;
            default:   closer = CH_SPACE;
        endcase
        if (!tok.esc && c == closer)
        begin
            close_token(1'b0);
            return;
        end
        if (tok.delim == DL_DOUBLE && !tok.esc && c == CH_BSLASH)
        begin
            tok.esc = 1'b1;
            return;
        end
        if (tok.esc)
        begin
            tok.esc = 1'b0;
            case (c)
                "a":     pack_byte(8'd7);
                "b":     pack_byte(8'd8);
                "e":     pack_byte(8'd27);
                "f":     pack_byte(8'd12);
                "n":     pack_byte(8'd10);
                "r":     pack_byte(8'd13);
                "t":     pack_byte(8'd9);
                "v":     pack_byte(8'd11);
                "x":
                begin
                    tok.hexcnt = HX_OPEN;
                    tok.hexval = 8'h00;
                end
                default: pack_byte(c);
            endcase
        end
        else
            pack_byte(c);
    endfunction

    function automatic void open_token(logic [7:0] c);
        tok.phase = PH_TOKEN;
        if (c == CH_DQUOTE) tok.delim = DL_DOUBLE;
        else if (c == CH_SQUOTE) tok.delim = DL_SINGLE;
        else
        begin
            tok.delim = DL_UNQ;
            take_token_char(c);
        end
    endfunction

    // Results of one accepted character land in step_results
    function automatic void predict_char(logic [7:0] c, logic le);
        quo_out_t r;
        step_results.delete();
        if (le || c == 8'h00)
        begin
            if (tok.phase == PH_PREFIX) close_token(1'b0);
            else if (tok.phase == PH_TOKEN) close_token(tok.delim != DL_UNQ);
            else tok.phase = PH_SKIP;
        end
        else if (tok.phase == PH_SKIP)
        begin
            if (c == CH_DOLLAR)
            begin
                tok.prefix = PF_HEX;
                tok.phase  = PH_PREFIX;
            end
            else if (c == CH_LT)
            begin
                tok.prefix = PF_FILE;
                tok.phase  = PH_PREFIX;
            end
            else if (c != CH_SPACE)
                open_token(c);
        end
        else if (tok.phase == PH_PREFIX)
            open_token(c);
        else
            take_token_char(c);
        if (step_results.size() > 0)
        begin
            r = step_results.pop_back();
            r.last = 1'b1;
            step_results.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------
    // Random line generation
    // ---------------------------------------------------------------

    function automatic void push_char(logic [7:0] c, logic le);
        char_feed.push_back('{c, le, 1'b0, 1'b0, NO_RESULT});
    endfunction

    function automatic logic [7:0] random_hex_char();
        logic [7:0] v;
        v = 8'($urandom_range(0, 15));
        if (v < 8'd10) return "0" + v;
        return ($urandom_range(0, 1) ? "a" : "A") + v - 8'd10;
    endfunction

    // Mostly well-formed token: spaces, prefix, quoting, body, closing
    function automatic void push_random_line();
        logic [1:0] delim_sel;
        logic [7:0] closer;
        logic [7:0] c;
        bit         hex_pfx;
        int         sel;
        repeat ($urandom_range(0, 2)) push_char(CH_SPACE, 1'b0);
        sel = $urandom_range(0, 3);
        hex_pfx = (sel == 0);
        if (sel == 0) push_char(CH_DOLLAR, 1'b0);
        else if (sel == 1) push_char(CH_LT, 1'b0);
        delim_sel = 2'($urandom_range(0, 2));
        closer = (delim_sel == 2'd1) ? CH_SQUOTE : (delim_sel == 2'd2) ? CH_DQUOTE : CH_SPACE;
        if (delim_sel != 2'd0) push_char(closer, 1'b0);
        repeat ($urandom_range(0, 6))
        begin
            sel = $urandom_range(0, 9);
            if (sel >= 5 && sel <= 7 && delim_sel == 2'd2)
            begin
                push_char(CH_BSLASH, 1'b0);
                c = ESC_PICK[$urandom_range(0, 11)];
                push_char(c, 1'b0);
                if (c == "x") repeat ($urandom_range(0, 3)) push_char(random_hex_char(), 1'b0);
            end
            else if (sel == 4 && hex_pfx)
                push_char((delim_sel == 2'd0) ? 8'($urandom_range(9, 13)) : CH_SPACE, 1'b0);
            else if (sel == 8)
                push_char(8'($urandom_range(1, 255)), 1'b0);
            else if (sel != 9)
            begin
                if (hex_pfx && $urandom_range(0, 3) != 0) c = random_hex_char();
                else c = 8'($urandom_range(33, 126));
                if (c == closer || c == CH_BSLASH) c = "m";
                push_char(c, 1'b0);
            end
        end
        // end of the token: cut short, backslash then zero, or proper close
        sel = $urandom_range(0, 9);
        if (sel == 0)
            push_char(8'($urandom_range(0, 255)), 1'b1);
        else if (sel == 1)
        begin
            push_char(CH_BSLASH, 1'b0);
            push_char(8'h00, 1'b0);
        end
        else
        begin
            push_char(closer, 1'b0);
            if (sel < 6) push_char(8'($urandom_range(0, 255)), 1'b1);
        end
    endfunction

    // ---------------------------------------------------------------
    // Character side: reset, drive, predict, finish
    // ---------------------------------------------------------------
    initial
    begin : drive_chars
        char_row_t row;
        int        idx;
        for (idx = 0; idx < DIR_N; idx++) char_feed.push_back(DIRECTED_ROWS[idx]);
        while (char_feed.size() < DIR_N + RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 5))
                    push_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 7) == 0));
            else
                push_random_line();
        end
        push_char(8'h00, 1'b1);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (idx = 0; idx < char_feed.size(); idx++)
        begin
            row = char_feed[idx];
            if (idx >= char_feed.size() - TAIL_ITEMS) quiet_tail = 1'b1;
            if (!quiet_tail && (idx % 40) < 25 && $urandom_range(0, 3) == 0)
            begin
                char_valid <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            char_valid <= 1'b1;
            char_item  <= '{char_in: row.ch, line_end: row.le};
            @(posedge clk);
            while (!char_ready) @(posedge clk);
            predict_char(row.ch, row.le);
            if (row.typed)
            begin
                if (row.has_want) expected_results.push_back(row.want);
            end
            else
                foreach (step_results[k]) expected_results.push_back(step_results[k]);
            @(negedge clk);
        end
        char_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // ---------------------------------------------------------------
    // Result side: random stall bursts, none in the tail
    // ---------------------------------------------------------------
    int stall_left = 0;
    int rcv_cycle = 0;

    always @(negedge clk)
    begin
        rcv_cycle++;
        if (stall_left > 0)
        begin
            stall_left--;
            res_ready <= 1'b0;
        end
        else if (!quiet_tail && (rcv_cycle % 300) < 200 && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 18) - 1;
            res_ready <= 1'b0;
        end
        else
            res_ready <= 1'b1;
    end

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Each result transaction against the oldest expectation
    always @(posedge clk)
    begin : check_results
        quo_out_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p", $time, res_item);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("kind", 16'(want.kind), 16'(res_item.kind));
                compare_field("data_byte", 16'(want.data_byte), 16'(res_item.data_byte));
                compare_field("token_length", want.token_length, res_item.token_length);
                compare_field("file_reference", 16'(want.file_reference),
                              16'(res_item.file_reference));
                compare_field("last", 16'(want.last), 16'(res_item.last));
            end
        end
    end

    // Watchdog: too long without any transaction on either side
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_valid && char_ready) || (res_valid && res_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/quo_pkg.sv
rtl/quo_step.sv
rtl/quo_res_fifo.sv
rtl/quoted_token_unescaper.sv
tb/quoted_token_unescaper_tb.sv
